// ===== src/e2q_pkg.sv =====
`default_nettype none

package e2q_pkg;

  localparam int ANG_W        = 15;
  localparam int IN_TDW       = 48;
  localparam int ZW           = 25;
  localparam int XW           = 32;
  localparam int PW           = 64;
  localparam int SW           = 65;
  localparam int NAX          = 3;
  localparam int AX_ROLL      = 0;
  localparam int AX_PITCH     = 1;
  localparam int AX_YAW       = 2;
  localparam int CORDIC_STEPS = 23;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = 2;

  localparam logic signed [XW-1:0] CORDIC_GAIN = 32'sd652032874;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 neg;
  } half_ang_t;

  typedef struct packed {
    half_ang_t [NAX-1:0] ang;
  } ang_item_t;

  typedef struct packed {
    logic      valid;
    ang_item_t item;
  } q_wr_t;

  typedef struct packed {
    logic      valid;
    ang_item_t item;
  } q_rd_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } crd_t;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      5'd0:    a = 25'sd2949120;
      5'd1:    a = 25'sd1740967;
      5'd2:    a = 25'sd919879;
      5'd3:    a = 25'sd466945;
      5'd4:    a = 25'sd234379;
      5'd5:    a = 25'sd117304;
      5'd6:    a = 25'sd58666;
      5'd7:    a = 25'sd29335;
      5'd8:    a = 25'sd14668;
      5'd9:    a = 25'sd7334;
      5'd10:   a = 25'sd3667;
      5'd11:   a = 25'sd1833;
      5'd12:   a = 25'sd917;
      5'd13:   a = 25'sd458;
      5'd14:   a = 25'sd229;
      5'd15:   a = 25'sd115;
      5'd16:   a = 25'sd57;
      5'd17:   a = 25'sd29;
      5'd18:   a = 25'sd14;
      5'd19:   a = 25'sd7;
      5'd20:   a = 25'sd4;
      5'd21:   a = 25'sd2;
      5'd22:   a = 25'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== src/e2q_front.sv =====
`default_nettype none

module e2q_front #(
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [e2q_pkg::IN_TDW-1:0] in_tdata,
  input  wire logic                      q_full,
  output e2q_pkg::q_wr_t                 q_wr
);

  import e2q_pkg::*;

  localparam int HALF_SH  = 15 - ANGLE_FRAC_BITS;
  localparam int TURN_RAW = 360 << (ANGLE_FRAC_BITS + 1);
  localparam int HALF_RAW = 180 << (ANGLE_FRAC_BITS + 1);
  localparam int QTR_RAW  = 90 << (ANGLE_FRAC_BITS + 1);
  localparam int NK       = 16384 / TURN_RAW + 1;
  localparam int RW       = 17;

  function automatic half_ang_t reduce(input logic signed [ANG_W-1:0] raw);
    logic signed [RW-1:0] wrap;
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] f;
    logic                 neg;
    half_ang_t            h;
    wrap = '0;
    for (int k = -NK; k <= NK; k++) begin
      if ((int'(raw) >= k * TURN_RAW - HALF_RAW) && (int'(raw) < k * TURN_RAW + HALF_RAW)) begin
        wrap = RW'(k * TURN_RAW);
      end
    end
    r = RW'(raw) - wrap;
    priority if (int'(r) > QTR_RAW) begin
      f   = RW'(int'(r) - HALF_RAW);
      neg = 1'b1;
    end else if (int'(r) < -QTR_RAW) begin
      f   = RW'(int'(r) + HALF_RAW);
      neg = 1'b1;
    end else begin
      f   = r;
      neg = 1'b0;
    end
    h.z   = ZW'(f) <<< HALF_SH;
    h.neg = neg;
    return h;
  endfunction

  assign in_tready = ~q_full;

  always_comb begin
    q_wr.valid             = in_tvalid & ~q_full;
    q_wr.item.ang[AX_ROLL]  = reduce(in_tdata[ANG_W-1:0]);
    q_wr.item.ang[AX_PITCH] = reduce(in_tdata[2*ANG_W-1:ANG_W]);
    q_wr.item.ang[AX_YAW]   = reduce(in_tdata[3*ANG_W-1:2*ANG_W]);
  end

endmodule

`default_nettype wire

// ===== src/e2q_queue.sv =====
`default_nettype none

module e2q_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire e2q_pkg::q_wr_t q_wr,
  output logic                q_full,
  output e2q_pkg::q_rd_t      q_rd,
  input  wire logic           q_pop
);

  import e2q_pkg::*;

  ang_item_t         ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign q_full     = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.item  = ent_r[rd_ptr_r];

  always_comb begin
    do_push    = q_wr.valid & ~q_full;
    do_pop     = q_pop & q_rd.valid;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= q_wr.item;
    end
  end

endmodule

`default_nettype wire

// ===== src/e2q_back.sv =====
`default_nettype none

module e2q_back #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire e2q_pkg::q_rd_t q_rd,
  output logic                q_pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [((4 * (OUT_FRAC_BITS + 2) + 7) / 8) * 8 - 1:0] out_tdata
);

  import e2q_pkg::*;

  localparam int OUT_W   = OUT_FRAC_BITS + 2;
  localparam int OUT_TDW = ((4 * OUT_W + 7) / 8) * 8;
  localparam int FSH     = 60 - OUT_FRAC_BITS;
  localparam int NV      = CORDIC_STEPS + 6;

  localparam logic signed [PW-1:0] RND29 = 64'sd536870912;
  localparam logic signed [SW-1:0] FRND  = 65'sd1 <<< (FSH - 1);
  localparam logic signed [SW-1:0] LIM   = 65'sd1 <<< OUT_FRAC_BITS;

  function automatic crd_t cordic_step(input crd_t c, input int sh);
    logic signed [XW-1:0] xv;
    logic signed [XW-1:0] yv;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] zv;
    logic signed [ZW-1:0] a;
    crd_t                 o;
    xv = c.x;
    yv = c.y;
    zv = c.z;
    dx = yv >>> sh;
    dy = xv >>> sh;
    a  = atan_deg(5'(sh));
    if (zv >= 0) begin
      o.x = xv - dx;
      o.y = yv + dy;
      o.z = zv - a;
    end else begin
      o.x = xv + dx;
      o.y = yv - dy;
      o.z = zv + a;
    end
    o.neg = c.neg;
    return o;
  endfunction

  logic                    advance;
  logic [NV-1:0]           vld_r;
  logic                    out_vld_r;
  crd_t                    crd_r [CORDIC_STEPS+1][NAX];
  logic signed [XW-1:0]    cos_r [NAX];
  logic signed [XW-1:0]    sin_r [NAX];
  logic signed [PW-1:0]    prod_r [4];
  logic signed [PW-1:0]    prod_nxt [4];
  logic signed [XW-1:0]    ab_r [4];
  logic signed [XW-1:0]    ab_nxt [4];
  logic signed [XW-1:0]    cy_b_r, sy_b_r, cy_c_r, sy_c_r;
  logic signed [PW-1:0]    term_r [8];
  logic signed [PW-1:0]    term_nxt [8];
  logic signed [SW-1:0]    sum_r [4];
  logic signed [SW-1:0]    sum_nxt [4];
  logic signed [OUT_W-1:0] q_r [4];
  logic signed [OUT_W-1:0] q_nxt [4];

  assign advance    = ~out_vld_r | out_tready;
  assign q_pop      = advance & q_rd.valid;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDW'({q_r[3], q_r[2], q_r[1], q_r[0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      vld_r     <= {vld_r[NV-2:0], q_rd.valid};
      out_vld_r <= vld_r[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int a = 0; a < NAX; a++) begin
        crd_r[0][a].x   <= CORDIC_GAIN;
        crd_r[0][a].y   <= '0;
        crd_r[0][a].z   <= q_rd.item.ang[a].z;
        crd_r[0][a].neg <= q_rd.item.ang[a].neg;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_crd
    always_ff @(posedge clk) begin
      if (advance) begin
        for (int a = 0; a < NAX; a++) begin
          crd_r[i+1][a] <= cordic_step(crd_r[i][a], i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int a = 0; a < NAX; a++) begin
        cos_r[a] <= crd_r[CORDIC_STEPS][a].neg ? -crd_r[CORDIC_STEPS][a].x
                                               :  crd_r[CORDIC_STEPS][a].x;
        sin_r[a] <= crd_r[CORDIC_STEPS][a].neg ? -crd_r[CORDIC_STEPS][a].y
                                               :  crd_r[CORDIC_STEPS][a].y;
      end
    end
  end

  // products: 0 cr*cp, 1 sr*sp, 2 sr*cp, 3 cr*sp
  always_comb begin
    prod_nxt[0] = cos_r[AX_ROLL] * cos_r[AX_PITCH];
    prod_nxt[1] = sin_r[AX_ROLL] * sin_r[AX_PITCH];
    prod_nxt[2] = sin_r[AX_ROLL] * cos_r[AX_PITCH];
    prod_nxt[3] = cos_r[AX_ROLL] * sin_r[AX_PITCH];
    for (int k = 0; k < 4; k++) begin
      ab_nxt[k] = XW'((prod_r[k] + RND29) >>> 30);
    end
    term_nxt[0] = ab_r[0] * cy_c_r;
    term_nxt[1] = ab_r[1] * sy_c_r;
    term_nxt[2] = ab_r[2] * cy_c_r;
    term_nxt[3] = ab_r[3] * sy_c_r;
    term_nxt[4] = ab_r[3] * cy_c_r;
    term_nxt[5] = ab_r[2] * sy_c_r;
    term_nxt[6] = ab_r[0] * sy_c_r;
    term_nxt[7] = ab_r[1] * cy_c_r;
    sum_nxt[0]  = SW'(term_r[0]) + SW'(term_r[1]);
    sum_nxt[1]  = SW'(term_r[2]) - SW'(term_r[3]);
    sum_nxt[2]  = SW'(term_r[4]) + SW'(term_r[5]);
    sum_nxt[3]  = SW'(term_r[6]) - SW'(term_r[7]);
  end

  always_comb begin
    logic signed [SW-1:0] rv;
    for (int k = 0; k < 4; k++) begin
      rv = (sum_r[k] + FRND) >>> FSH;
      priority if (rv > LIM) begin
        q_nxt[k] = OUT_W'(LIM);
      end else if (rv < -LIM) begin
        q_nxt[k] = OUT_W'(-LIM);
      end else begin
        q_nxt[k] = OUT_W'(rv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r <= prod_nxt;
      cy_b_r <= cos_r[AX_YAW];
      sy_b_r <= sin_r[AX_YAW];
      ab_r   <= ab_nxt;
      cy_c_r <= cy_b_r;
      sy_c_r <= sy_b_r;
      term_r <= term_nxt;
      sum_r  <= sum_nxt;
      q_r    <= q_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/euler_to_quaternion_unit.sv =====
`default_nettype none

// Channel   Ports                          tdata fields (lowest bit up)
// in_       in_tvalid/in_tready/in_tdata   roll_deg[14:0] pitch_deg[29:15] yaw_deg[44:30]
// out_      out_tvalid/out_tready/out_tdata quat_w quat_x quat_y quat_z, OUT_FRAC_BITS+2 each
//
// One item per cycle sustained while out_tready holds high; with the queue empty and no
// output stall an accepted item goes through the queue into the CORDIC load stage,
// then 23 CORDIC stages, then six sign/product/round stages to the output.
// Reset clears the queue pointers and count and the pipeline valid bits only.
// An item held at the output with out_tready low freezes the back pipeline; the
// 4-entry queue keeps taking items until it fills, then in_tready drops.

module euler_to_quaternion_unit #(
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int OUT_FRAC_BITS   = 14
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [e2q_pkg::IN_TDW-1:0] in_tdata,   // roll_deg, pitch_deg, yaw_deg
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [((4 * (OUT_FRAC_BITS + 2) + 7) / 8) * 8 - 1:0] out_tdata // quat_w, x, y, z
);

  import e2q_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  e2q_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  e2q_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  e2q_back #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rd       (q_rd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
